### src/modexp_pkg.sv
// modexp_pkg: shared widths, constants and handshake structs for the
// modular exponentiation block. Used by the divider, the multiplier unit and
// the top level. No dependencies.
`default_nettype none

package modexp_pkg;

  localparam int M_W     = 30;
  localparam int BASE_W  = 64;
  localparam int EXP_W   = 63;
  localparam int DIV_W   = 64;
  localparam int MU_W    = 32;
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 2 * M_W;
  localparam int R_W     = 32;
  localparam int NLEN_W  = 5;

  localparam logic [M_W-1:0] MOD_RESET = 30'd1000000007;
  localparam logic [M_W-1:0] MOD_MIN   = 30'd2;

  typedef enum logic {
    KIND_POWER   = 1'b0,
    KIND_INVERSE = 1'b1
  } kind_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [M_W-1:0]   remainder;
  } div_rsp_t;

  typedef struct packed {
    logic           start;
    logic [M_W-1:0] a;
    logic [M_W-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic           done;
    logic [M_W-1:0] res;
  } mm_rsp_t;

endpackage

`default_nettype wire

### src/modular_exponentiation.sv
// modular_exponentiation: square-and-multiply sequencer, top level.
// Uses modexp_div for base residue and Barrett constant, modexp_mul for
// products. Depends on modexp_pkg.
// Sequence: two divider passes (base residue, then Barrett constant), then per
// exponent bit a Barrett product for the square and one for the multiply when
// the bit is set; leading zero bits make no product, the first set bit loads the base.
// A modulus below two gives its result the cycle after start. One item at a
// time: start is taken while busy is low; the receiver cannot stall results.
// Synchronous reset idles the block and sets modulus to 1000000007.
`default_nettype none

module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int EXP_BITS = 63
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              kind,
  input  wire logic signed [BASE_W-1:0] base,
  input  wire logic [EXP_W-1:0]  exponent,
  input  wire logic              cfg_write,
  input  wire logic [M_W-1:0]    cfg_data,
  output logic                   done,
  output logic [M_W-1:0]         result
);

  localparam int IDX_W = $clog2(EXP_BITS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIVB  = 7'b0000010,
    S_DIVMU = 7'b0000100,
    S_SQ    = 7'b0001000,
    S_WSQ   = 7'b0010000,
    S_ML    = 7'b0100000,
    S_WML   = 7'b1000000
  } state_t;

  function automatic logic [NLEN_W-1:0] bit_len(input logic [M_W-1:0] v);
    logic [NLEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < M_W; i++) begin
      if (v[i]) n = NLEN_W'(i + 1);
    end
    return n;
  endfunction

  state_t state;

  logic [M_W-1:0]      modulus;
  logic [M_W-1:0]      m_r;
  logic [NLEN_W-1:0]   nlen_r;
  logic                neg_r;
  logic                kind_r;
  logic [EXP_BITS-1:0] exp_r;
  logic [IDX_W-1:0]    idx;
  logic                started;
  logic [M_W-1:0]      bres;
  logic [M_W-1:0]      acc;
  logic [MU_W-1:0]     mu_r;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mm_req_t  mm_req;
  mm_rsp_t  mm_rsp;

  logic [BASE_W-1:0] mag;
  logic              bit_set;
  logic [M_W-1:0]    acc_ml;

  always_comb begin
    mag     = ~$unsigned(base) + BASE_W'(1);
    bit_set = exp_r[idx];
    if (bit_set && !started) begin
      acc_ml = bres;
    end else if (started) begin
      acc_ml = acc;
    end else begin
      acc_ml = M_W'(1);
    end
  end

  assign busy = (state != S_IDLE);

  modexp_div u_div (
    .clk     (clk),
    .rst     (rst),
    .req     (div_req),
    .divisor (m_r),
    .rsp     (div_rsp)
  );

  modexp_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mm_req),
    .m    (m_r),
    .mu   (mu_r),
    .nlen (nlen_r),
    .rsp  (mm_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      div_req.start <= 1'b0;
      mm_req.start  <= 1'b0;
      modulus       <= MOD_RESET;
    end else begin
      done          <= 1'b0;
      div_req.start <= 1'b0;
      mm_req.start  <= 1'b0;
      if (cfg_write) modulus <= cfg_data;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (modulus < MOD_MIN) begin
              done   <= 1'b1;
              result <= '0;
            end else begin
              m_r              <= modulus;
              nlen_r           <= bit_len(modulus);
              kind_r           <= kind;
              neg_r            <= base[BASE_W-1];
              exp_r            <= exponent[EXP_BITS-1:0];
              div_req.start    <= 1'b1;
              div_req.dividend <= base[BASE_W-1] ? mag : $unsigned(base);
              state            <= S_DIVB;
            end
          end
        end
        S_DIVB: begin
          if (div_rsp.done) begin
            if (neg_r && div_rsp.remainder != '0) begin
              bres <= m_r - div_rsp.remainder;
            end else begin
              bres <= div_rsp.remainder;
            end
            div_req.start    <= 1'b1;
            div_req.dividend <= DIV_W'(1) << {nlen_r, 1'b0};
            state            <= S_DIVMU;
          end
        end
        S_DIVMU: begin
          if (div_rsp.done) begin
            mu_r    <= div_rsp.quotient[MU_W-1:0];
            started <= 1'b0;
            idx     <= IDX_W'(EXP_BITS - 1);
            if (kind_r == KIND_INVERSE) exp_r <= EXP_BITS'(m_r - MOD_MIN);
            if (kind_r == KIND_INVERSE && bres == '0) begin
              done   <= 1'b1;
              result <= '0;
              state  <= S_IDLE;
            end else begin
              state <= S_SQ;
            end
          end
        end
        S_SQ: begin
          if (started) begin
            mm_req.start <= 1'b1;
            mm_req.a     <= acc;
            mm_req.b     <= acc;
            state        <= S_WSQ;
          end else begin
            state <= S_ML;
          end
        end
        S_WSQ: begin
          if (mm_rsp.done) begin
            acc   <= mm_rsp.res;
            state <= S_ML;
          end
        end
        S_ML: begin
          if (bit_set && started) begin
            mm_req.start <= 1'b1;
            mm_req.a     <= acc;
            mm_req.b     <= bres;
            state        <= S_WML;
          end else begin
            // first set bit loads the base directly
            if (bit_set) begin
              acc     <= bres;
              started <= 1'b1;
            end
            if (idx == '0) begin
              done   <= 1'b1;
              result <= acc_ml;
              state  <= S_IDLE;
            end else begin
              idx   <= idx - IDX_W'(1);
              state <= S_SQ;
            end
          end
        end
        S_WML: begin
          if (mm_rsp.done) begin
            acc <= mm_rsp.res;
            if (idx == '0) begin
              done   <= 1'b1;
              result <= mm_rsp.res;
              state  <= S_IDLE;
            end else begin
              idx   <= idx - IDX_W'(1);
              state <= S_SQ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    done && m_r >= MOD_MIN && state == S_IDLE && $past(state) != S_IDLE
      |-> result < m_r)
    else $error("result not reduced below modulus");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result strobe while still working");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIVB || state == S_DIVMU)
    else $error("divider finished outside a divide step");

  a_mul_owner: assert property (@(posedge clk) disable iff (rst)
    mm_rsp.done |-> state == S_WSQ || state == S_WML)
    else $error("multiplier finished outside a wait step");

endmodule

`default_nettype wire

### src/modexp_div.sv
// modexp_div: bit-serial restoring divider, one quotient bit per cycle.
// Gives quotient and remainder of a 64-bit dividend by the modulus.
// Depends on modexp_pkg.
`default_nettype none

module modexp_div
  import modexp_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire div_req_t       req,
  input  wire logic [M_W-1:0] divisor,
  output div_rsp_t            rsp
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] quo;
  logic [M_W-1:0]   rem;
  logic [M_W-1:0]   d;

  logic [M_W:0] shifted;
  logic [M_W:0] diff;
  logic         ge;

  always_comb begin
    shifted = {rem, quo[DIV_W-1]};
    diff    = shifted - {1'b0, d};
    ge      = shifted >= {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= req.dividend;
        rem  <= '0;
        d    <= divisor;
      end else if (busy) begin
        rem <= ge ? diff[M_W-1:0] : shifted[M_W-1:0];
        quo <= {quo[DIV_W-2:0], ge};
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

`default_nettype wire

### src/modexp_mul.sv
// modexp_mul: Barrett modular multiplier around one shared 32x32 multiplier.
// Product, quotient estimate and quotient times modulus take three passes.
// Depends on modexp_pkg.
`default_nettype none

module modexp_mul
  import modexp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mm_req_t           req,
  input  wire logic [M_W-1:0]    m,
  input  wire logic [MU_W-1:0]   mu,
  input  wire logic [NLEN_W-1:0] nlen,
  output mm_rsp_t                rsp
);

  typedef enum logic [5:0] {
    MM_IDLE = 6'b000001,
    MM_MUL1 = 6'b000010,
    MM_MUL2 = 6'b000100,
    MM_MUL3 = 6'b001000,
    MM_SUB  = 6'b010000,
    MM_COR  = 6'b100000
  } mm_state_t;

  mm_state_t state;

  logic [M_W-1:0]    a_r;
  logic [M_W-1:0]    b_r;
  logic [PROD_W-1:0] p;
  logic [2*MUL_W-1:0] t;
  logic [R_W-1:0]    qm;
  logic [R_W-1:0]    r;
  logic [M_W-1:0]    res;
  logic              done;

  logic [NLEN_W-1:0]  sh_lo;
  logic [NLEN_W-1:0]  sh_hi;
  logic [MUL_W-1:0]   mul_x;
  logic [MUL_W-1:0]   mul_y;
  logic [2*MUL_W-1:0] prod;
  logic [R_W-1:0]     m1;
  logic [R_W-1:0]     m2;

  always_comb begin
    sh_lo = nlen - NLEN_W'(1);
    sh_hi = nlen + NLEN_W'(1);
    case (state)
      MM_MUL1: begin
        mul_x = MUL_W'(a_r);
        mul_y = MUL_W'(b_r);
      end
      MM_MUL2: begin
        mul_x = MUL_W'(p >> sh_lo);
        mul_y = mu;
      end
      MM_MUL3: begin
        mul_x = MUL_W'(t >> sh_hi);
        mul_y = MUL_W'(m);
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
    prod = mul_x * mul_y;
    m1   = R_W'(m);
    m2   = R_W'({m, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MM_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        MM_IDLE: begin
          if (req.start) begin
            a_r   <= req.a;
            b_r   <= req.b;
            state <= MM_MUL1;
          end
        end
        MM_MUL1: begin
          p     <= prod[PROD_W-1:0];
          state <= MM_MUL2;
        end
        MM_MUL2: begin
          t     <= prod;
          state <= MM_MUL3;
        end
        MM_MUL3: begin
          qm    <= prod[R_W-1:0];
          state <= MM_SUB;
        end
        MM_SUB: begin
          r     <= p[R_W-1:0] - qm;
          state <= MM_COR;
        end
        MM_COR: begin
          if (r >= m2) begin
            res <= M_W'(r - m2);
          end else if (r >= m1) begin
            res <= M_W'(r - m1);
          end else begin
            res <= M_W'(r);
          end
          done  <= 1'b1;
          state <= MM_IDLE;
        end
        default: state <= MM_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.res  = res;

endmodule

`default_nettype wire

### verif/tb_modular_exponentiation.sv
// tb_modular_exponentiation: self-checking testbench for the modular exponentiation block.
// Drives directed and random power/inverse requests over several moduli and checks each
// result against an in-bench predictor. Depends on modexp_pkg and modular_exponentiation.
`timescale 1ns / 1ps
`default_nettype none

module tb_modular_exponentiation
  import modexp_pkg::*;
();

  localparam int EXP_BITS = 63;
  localparam int PHASE_ITEMS = 135;
  localparam int unsigned MOD_MAX = 32'h3FFF_FFFF;

  class modexp_scoreboard;
    logic [M_W-1:0] modulus;
    logic [M_W-1:0] expected_residues[$];
    int unsigned mismatches;

    function new();
      modulus = MOD_RESET;
      mismatches = 0;
    endfunction

    function logic [M_W-1:0] predict_power(kind_t k, logic [63:0] raw, logic [62:0] e);
      logic [63:0] m, mag, r, b, acc, ex;
      m = {34'd0, modulus};
      if (m < 64'd2) return '0;
      if (!raw[63]) begin
        b = raw % m;
      end else begin
        mag = ~raw + 64'd1;
        r = mag % m;
        b = (r != 64'd0) ? m - r : 64'd0;
      end
      ex = {1'b0, e};
      if (k == KIND_INVERSE) begin
        if (b == 64'd0) return '0;
        ex = m - 64'd2;
      end
      acc = 64'd1;
      for (int i = EXP_BITS - 1; i >= 0; i--) begin
        acc = (acc * acc) % m;
        if (ex[i]) acc = (acc * b) % m;
      end
      return acc[M_W-1:0];
    endfunction

    function void note_request(kind_t k, logic [63:0] raw, logic [62:0] e);
      expected_residues = {expected_residues, predict_power(k, raw, e)};
    endfunction

    function void check_result(logic [M_W-1:0] got);
      logic [M_W-1:0] want;
      if (expected_residues.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d, nothing outstanding", got);
      end else begin
        want = expected_residues.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %0d, got %0d (modulus %0d)", want, got, modulus);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_residues.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic kind = 1'b0;
  logic signed [BASE_W-1:0] base = '0;
  logic [EXP_W-1:0] exponent = '0;
  logic cfg_write = 1'b0;
  logic [M_W-1:0] cfg_data = '0;
  logic busy;
  logic done;
  logic [M_W-1:0] result;

  modexp_scoreboard sb;
  logic [M_W-1:0] cur_modulus = MOD_RESET;
  bit no_idle = 1'b0;

  modular_exponentiation #(.EXP_BITS(EXP_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .base(base),
    .exponent(exponent),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .done(done),
    .result(result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(result);
  end

  task automatic issue_request(input kind_t k, input logic [63:0] b, input logic [62:0] e);
    int unsigned r;
    int unsigned gap;
    start <= 1'b1;
    kind <= k;
    base <= b;
    exponent <= e;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(k, b, e);
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 20);
    else gap = $urandom_range(50, 200);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [M_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.modulus = value;
    cur_modulus = value;
  endtask

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [M_W-1:0] phase_moduli [11];
    kind_t k;
    logic [63:0] b;
    logic [62:0] e;
    longint v;
    int unsigned sel;
    int unsigned w;

    sb = new();
    phase_moduli = '{30'd2, 30'd3, 30'h3FFF_FFFF, 30'd1073741789, 30'd0, 30'd1,
                     30'd65537, 30'd0, 30'd1000000007, 30'd0, 30'd5};
    phase_moduli[7] = M_W'($urandom_range(2, MOD_MAX));
    phase_moduli[9] = M_W'($urandom_range(2, MOD_MAX));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed requests at the reset modulus
    issue_request(KIND_POWER, 64'd2, 63'd0);
    issue_request(KIND_POWER, 64'd0, 63'd0);
    issue_request(KIND_POWER, 64'd0, 63'd5);
    issue_request(KIND_POWER, 64'd1, '1);
    issue_request(KIND_POWER, '1, '1);
    issue_request(KIND_POWER, '1, {{62{1'b1}}, 1'b0});
    issue_request(KIND_POWER, 64'h7FFF_FFFF_FFFF_FFFF, '1);
    issue_request(KIND_POWER, 64'h8000_0000_0000_0000, '1);
    issue_request(KIND_POWER, 64'h8000_0000_0000_0000, 63'd1);
    issue_request(KIND_POWER, 64'h7FFF_FFFF_FFFF_FFFF, 63'd1);
    issue_request(KIND_POWER, 64'd1000000007, 63'd3);
    issue_request(KIND_POWER, -64'sd1000000007, 63'd0);
    issue_request(KIND_POWER, 64'd123456789, 63'h4000_0000_0000_0000);
    issue_request(KIND_INVERSE, 64'd0, 63'd0);
    issue_request(KIND_INVERSE, 64'd1000000007, 63'd7);
    issue_request(KIND_INVERSE, -64'sd2000000014, 63'd0);
    issue_request(KIND_INVERSE, 64'd2, 63'd0);
    issue_request(KIND_INVERSE, '1, 63'd0);
    issue_request(KIND_INVERSE, 64'h7FFF_FFFF_FFFF_FFFF, 63'd0);
    issue_request(KIND_INVERSE, 64'h8000_0000_0000_0000, 63'd0);
    issue_request(KIND_POWER, 64'd3, 63'd1000000005);
    issue_request(KIND_POWER, -64'sd5, 63'h5555_5555_5555_5555);
    issue_request(KIND_INVERSE, 64'd1, '1);

    for (int p = 0; p < 11; p++) begin
      drain_results();
      write_modulus(phase_moduli[p]);
      no_idle = (p % 4 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        k = ($urandom_range(0, 3) == 0) ? KIND_INVERSE : KIND_POWER;
        sel = $urandom_range(0, 15);
        if (sel < 4) begin
          v = longint'(int'($urandom_range(0, 40))) - 64'sd20;
          b = v;
        end else if (sel < 6) begin
          v = longint'(int'($urandom)) * longint'({34'd0, cur_modulus});
          b = v;
        end else begin
          b = {$urandom, $urandom};
        end
        e = 63'({$urandom, $urandom} >> 1);
        sel = $urandom_range(0, 15);
        if (sel < 10) w = $urandom_range(0, 20);
        else if (sel < 14) w = $urandom_range(0, 62);
        else w = 63;
        if (w < 63) e = e & ((63'd1 << w) - 63'd1);
        issue_request(k, b, e);
      end
    end

    drain_results();
    repeat (1100) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
